// ===== src/ukt_pkg.sv =====
package ukt_pkg;

	// Request codes.
	typedef enum logic [2:0] {
		REQ_FIND   = 3'd0,
		REQ_ADD    = 3'd1,
		REQ_REMOVE = 3'd2,
		REQ_ACCESS = 3'd3,
		REQ_RD_KEY = 3'd4,
		REQ_RD_LOG = 3'd5
	} req_t;

	// Status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_PRESENT = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_RANGE   = 2'd3;

	localparam int ID_W = 56;

	// Keeps the first len bytes and clears the rest.
	function automatic logic [ID_W-1:0] mask_bytes(input logic [2:0] len,
		input logic [ID_W-1:0] b);
		logic [ID_W-1:0] m;
		m = '0;
		for (int i = 0; i < ID_W / 8; i++) begin
			if (3'(i) < len) begin
				m[i*8 +: 8] = 8'hFF;
			end
		end
		return b & m;
	endfunction

endpackage

// ===== src/ukt_ram.sv =====
module ukt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/uid_key_table_with_access_log.sv =====
// Find, add and access compare the stored keys in order from slot 0 and stop at the first
// match or at the key count; remove, the reads and unused codes do no scan. One request
// is in work at a time; a new word can be taken in the cycle after the result word is
// taken. Reset clears the key count, log head and log count, then sweeps every slot of
// the log store to zero before a word is taken.
module uid_key_table_with_access_log import ukt_pkg::*; #(
	parameter int KEY_SLOTS    = 40,
	parameter int LOG_SLOTS    = 16,
	parameter int MAX_ID_BYTES = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       req_type,
	input  logic [2:0]       uid_len,
	input  logic [ID_W-1:0]  uid_bytes,
	input  logic [5:0]       slot_index,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output logic             found,
	output logic [5:0]       found_index,
	output logic [5:0]       key_count,
	output logic [3:0]       log_count,
	output logic [3:0]       log_head,
	output logic [2:0]       read_len,
	output logic             read_accepted,
	output logic [ID_W-1:0]  read_bytes
);

	localparam int KA = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int LA = $clog2(LOG_SLOTS);
	localparam int KW = 3 + ID_W;
	localparam int LW = 4 + ID_W;
	localparam logic [6:0] KEY_MAX = 7'(KEY_SLOTS);
	localparam logic [4:0] LOG_MAX = 5'(LOG_SLOTS);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SCAN, S_SCAN_WAIT, S_SCAN_CHK, S_DECIDE,
		S_RM_WAIT, S_RM_WR, S_RD_WAIT, S_RD_DONE, S_OUT
	} state_t;

	state_t             state_q;
	logic [2:0]         req_q;
	logic [2:0]         len_q;
	logic [ID_W-1:0]    bytes_q;
	logic [5:0]         slot_q;
	logic [6:0]         kcnt_q;
	logic [3:0]         lhead_q;
	logic [3:0]         lcnt_q;
	logic [6:0]         scan_q;
	logic               hit_q;
	logic [5:0]         hit_idx_q;
	logic [LA:0]        clr_q;

	// Key RAM ports.
	logic               k_we;
	logic [KA-1:0]      k_waddr, k_raddr;
	logic [KW-1:0]      k_wdata, k_rdata;
	// Log RAM ports.
	logic               l_we;
	logic [LA-1:0]      l_waddr, l_raddr;
	logic [LW-1:0]      l_wdata, l_rdata;

	ukt_ram #(.WIDTH(KW), .DEPTH(KEY_SLOTS)) u_key_ram (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
		.raddr(k_raddr), .rdata(k_rdata)
	);

	ukt_ram #(.WIDTH(LW), .DEPTH(LOG_SLOTS)) u_log_ram (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);

	// Clamped length and masked bytes of the incoming word.
	logic [2:0]      in_len;
	logic [ID_W-1:0] in_bytes;
	always_comb begin
		in_len = (uid_len > 3'(MAX_ID_BYTES)) ? 3'(MAX_ID_BYTES) : uid_len;
		in_bytes = mask_bytes(in_len, uid_bytes);
	end

	logic key_match;
	assign key_match = (k_rdata[KW-1 -: 3] == len_q) && (k_rdata[ID_W-1:0] == bytes_q);

	logic slot_ok_key;
	assign slot_ok_key = {1'b0, slot_q} < kcnt_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign key_count = kcnt_q[5:0];
	assign log_count = lcnt_q;
	assign log_head  = lhead_q;

	// Memory port control.
	always_comb begin
		k_we    = 1'b0;
		k_waddr = slot_q[KA-1:0];
		k_wdata = k_rdata;
		k_raddr = scan_q[KA-1:0];
		l_we    = 1'b0;
		l_waddr = lhead_q[LA-1:0];
		l_wdata = {hit_q, len_q, bytes_q};
		l_raddr = slot_q[LA-1:0];
		case (state_q)
			S_CLEAR: begin
				l_we    = 1'b1;
				l_waddr = clr_q[LA-1:0];
				l_wdata = '0;
			end
			S_IDLE: begin
				k_raddr = slot_index[KA-1:0];
			end
			S_DECIDE: begin
				if (req_q == REQ_ADD && !hit_q && kcnt_q < KEY_MAX) begin
					k_we    = 1'b1;
					k_waddr = kcnt_q[KA-1:0];
					k_wdata = {len_q, bytes_q};
				end
				if (req_q == REQ_ACCESS) begin
					l_we = 1'b1;
				end
			end
			S_RM_WAIT: begin
				k_raddr = KA'(kcnt_q - 7'd1);
			end
			S_RM_WR: begin
				k_we = 1'b1;
			end
			// Keep the requested key slot on the read port for the read result.
			S_RD_WAIT: begin
				k_raddr = slot_q[KA-1:0];
			end
			default: begin
			end
		endcase
	end

	// Control sequencer with result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			kcnt_q        <= '0;
			lhead_q       <= '0;
			lcnt_q        <= '0;
			clr_q         <= '0;
			scan_q        <= '0;
			hit_q         <= 1'b0;
			hit_idx_q     <= '0;
			req_q         <= '0;
			len_q         <= '0;
			bytes_q       <= '0;
			slot_q        <= '0;
			status        <= ST_OK;
			found         <= 1'b0;
			found_index   <= '0;
			read_len      <= '0;
			read_accepted <= 1'b0;
			read_bytes    <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (LA + 1)'(LOG_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q         <= req_type;
						len_q         <= in_len;
						bytes_q       <= in_bytes;
						slot_q        <= slot_index;
						scan_q        <= '0;
						hit_q         <= 1'b0;
						hit_idx_q     <= '0;
						status        <= ST_OK;
						found         <= 1'b0;
						found_index   <= '0;
						read_len      <= '0;
						read_accepted <= 1'b0;
						read_bytes    <= '0;
						case (req_type)
							REQ_FIND, REQ_ADD, REQ_ACCESS: state_q <= S_SCAN;
							REQ_REMOVE: state_q <= S_RM_WAIT;
							REQ_RD_KEY, REQ_RD_LOG: state_q <= S_RD_WAIT;
							default: state_q <= S_OUT;
						endcase
					end
				end
				// Issue a read of slot scan_q, or stop at the count.
				S_SCAN: begin
					if (scan_q >= kcnt_q) begin
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_SCAN_WAIT;
					end
				end
				S_SCAN_WAIT: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (key_match) begin
						hit_q     <= 1'b1;
						hit_idx_q <= scan_q[5:0];
						state_q   <= S_DECIDE;
					end else begin
						scan_q  <= scan_q + 7'd1;
						state_q <= S_SCAN;
					end
				end
				S_DECIDE: begin
					state_q <= S_OUT;
					case (req_q)
						REQ_ADD: begin
							if (hit_q) begin
								status <= ST_PRESENT;
							end else if (kcnt_q >= KEY_MAX) begin
								status <= ST_FULL;
							end else begin
								kcnt_q <= kcnt_q + 7'd1;
							end
						end
						REQ_ACCESS: begin
							found       <= hit_q;
							found_index <= hit_idx_q;
							lhead_q <= ({1'b0, lhead_q} + 5'd1 >= LOG_MAX) ?
								4'd0 : lhead_q + 4'd1;
							if ({1'b0, lcnt_q} < LOG_MAX - 5'd1) begin
								lcnt_q <= lcnt_q + 4'd1;
							end
						end
						default: begin
							found       <= hit_q;
							found_index <= hit_idx_q;
						end
					endcase
				end
				S_RM_WAIT: begin
					if (!slot_ok_key) begin
						status  <= ST_RANGE;
						state_q <= S_OUT;
					end else begin
						state_q <= S_RM_WR;
					end
				end
				S_RM_WR: begin
					kcnt_q  <= kcnt_q - 7'd1;
					state_q <= S_OUT;
				end
				S_RD_WAIT: begin
					state_q <= S_RD_DONE;
				end
				S_RD_DONE: begin
					state_q <= S_OUT;
					if (req_q == REQ_RD_KEY) begin
						if (!slot_ok_key) begin
							status <= ST_RANGE;
						end else begin
							read_len   <= k_rdata[KW-1 -: 3];
							read_bytes <= k_rdata[ID_W-1:0];
						end
					end else begin
						if ({1'b0, slot_q} >= 7'(LOG_MAX)) begin
							status <= ST_RANGE;
						end else begin
							read_accepted <= l_rdata[LW-1];
							read_len      <= l_rdata[LW-2 -: 3];
							read_bytes    <= l_rdata[ID_W-1:0];
						end
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
